[design/lpmf_pkg.sv]
// shared types and constants of the length-prefixed message queue
package lpmf_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 10;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // request kinds carried on the slave tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_POP   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    // result status carried on the master tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

[design/length_prefixed_message_fifo.sv]
// queue of variable-length byte messages in one circular byte memory
//
//  channel  | direction | tuser          | tdata (lowest bit up)                | tlast
//  ---------+-----------+----------------+--------------------------------------+---------
//  s_axis   | in        | req_type       | data_byte, msg_len, zero fill        | unused
//  m_axis   | out       | status         | rd_byte, head_len, is_empty, zeros   | rd_last
//
// every accepted request gives one result transaction. a report-only request (drop, empty,
// clear) goes straight to the closing step, a pushed byte writes memory first, a read reads
// it first, and a new message's first byte adds one memory write per header byte. after a pop,
// or a new message into an empty queue, the head length is fetched again: two more memory reads
// (one for a 1-byte header). all of it is set by the memory's single write / single read port.
// rst_n clears pointers and flags at once; the byte memory is not cleared.
// a finished result waits in the output register while the next request is taken; only the
// closing step of that request stalls until the master side frees the register.
module length_prefixed_message_fifo #(
    parameter int BUF_BYTES     = 4096,
    parameter int MAX_MSG_BYTES = 1023,
    parameter int HEADER_BYTES  = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // data_byte [7:0], msg_len [17:8], zero fill above
    input  logic [lpmf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // req_type [1:0]
    input  logic [lpmf_pkg::REQ_W-1:0]            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // rd_byte [7:0], head_len [17:8], is_empty [18], zero fill above
    output logic [lpmf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // status [1:0]
    output logic [lpmf_pkg::STATUS_W-1:0]         m_axis_tuser,
    // rd_last
    output logic                                  m_axis_tlast
);

    localparam int LW = lpmf_pkg::LEN_W;
    localparam int BW = lpmf_pkg::BYTE_W;
    // memory address, pointer (may equal the buffer size) and wide sum widths
    localparam int AW = $clog2(BUF_BYTES);
    localparam int PW = $clog2(BUF_BYTES + 1);
    localparam int WW = $clog2(BUF_BYTES + HEADER_BYTES + 1024);
    localparam int KW = $clog2(HEADER_BYTES + 1);

    localparam logic [WW-1:0] BUF_W     = WW'(BUF_BYTES);
    localparam logic [WW-1:0] HB_W      = WW'(HEADER_BYTES);
    localparam logic [KW-1:0] HB_K      = KW'(HEADER_BYTES);
    localparam logic [11:0]   MAX_L     = 12'(MAX_MSG_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUF_BYTES - 1);
    localparam logic [PW-1:0] BUF_P     = PW'(BUF_BYTES);
    localparam int OUT_PAD = lpmf_pkg::OUT_TDATA_W - BW - LW - 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_REFRESH,
        S_HDR_A,
        S_HDR_B,
        S_HDR_C,
        S_DONE
    } state_t;

    // byte memory with one write and one registered read port
    logic [BW-1:0] byte_mem [BUF_BYTES];
    logic [BW-1:0] mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [BW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    state_t state_reg, state_next;

    // queue pointers and progress
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] rewind_reg, rewind_next;
    logic          rewind_valid_reg, rewind_valid_next;
    logic          empty_reg, empty_next;
    logic          drop_reg, drop_next;
    logic [LW-1:0] push_rem_reg, push_rem_next;
    logic [LW-1:0] rd_off_reg, rd_off_next;

    // current transaction
    logic [BW-1:0]         data_reg, data_next;
    logic [LW-1:0]         len_reg, len_next;
    lpmf_pkg::status_t     status_reg, status_next;
    logic [BW-1:0]         rbyte_reg, rbyte_next;
    logic                  rlast_reg, rlast_next;
    logic [AW-1:0]         wr_addr_reg, wr_addr_next;
    logic [KW-1:0]         wr_k_reg, wr_k_next;
    logic [WW-1:0]         rd_addr_reg, rd_addr_next;

    // copy of the length bytes of the front header
    logic [BW-1:0] hdr0_reg, hdr0_next;
    logic [1:0]    hdr1_reg, hdr1_next;
    logic          cache_valid_reg, cache_valid_next;
    logic [PW-1:0] cache_at_reg, cache_at_next;
    logic [AW-1:0] cache_a0_reg, cache_a0_next;
    logic [AW-1:0] cache_a1_reg, cache_a1_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    lpmf_pkg::status_t     out_status_reg, out_status_next;
    logic [BW-1:0]         out_rbyte_reg, out_rbyte_next;
    logic                  out_rlast_reg, out_rlast_next;
    logic [LW-1:0]         out_hlen_reg, out_hlen_next;
    logic                  out_empty_reg, out_empty_next;

    // request fields
    logic [BW-1:0] in_data;
    logic [LW-1:0] in_len;
    logic          accept;

    // derived values
    logic [LW-1:0] cache_len;
    logic [PW-1:0] front;
    logic          need_hdr;
    logic [WW-1:0] size_w;
    logic [WW-1:0] head_w;
    logic [WW-1:0] tail_w;
    logic          fit;
    logic          fit_reset;
    logic          fit_rewind;
    logic [WW-1:0] fit_base;
    logic          too_long;
    logic [WW-1:0] pop_tail;
    logic [WW-1:0] pop_next;
    logic [AW-1:0] a1_addr;
    logic [BW-1:0] wr_byte;

    assign in_data = s_axis_tdata[BW-1:0];
    assign in_len  = s_axis_tdata[BW+LW-1:BW];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_rlast_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_empty_reg, out_hlen_reg, out_rbyte_reg};

    // a one-byte header keeps only the low byte of the length
    assign cache_len = (HEADER_BYTES == 1) ? {2'b00, hdr0_reg} : {hdr1_reg, hdr0_reg};

    // after a wrap the front message sits at the start once the tail reaches the mark
    assign front    = (rewind_valid_reg && (tail_reg == rewind_reg)) ? '0 : tail_reg;
    assign need_hdr = !empty_reg && !(cache_valid_reg && (cache_at_reg == front));

    assign size_w   = WW'(in_len) + HB_W;
    assign head_w   = WW'(head_reg);
    assign tail_w   = WW'(tail_reg);
    assign too_long = {2'b00, in_len} > MAX_L;

    // room search for header plus message
    always_comb
    begin
        fit        = 1'b0;
        fit_reset  = 1'b0;
        fit_rewind = 1'b0;
        fit_base   = head_w;
        priority if (tail_reg == head_reg)
        begin
            if (empty_reg && (size_w <= BUF_W))
            begin
                fit       = 1'b1;
                fit_reset = 1'b1;
                fit_base  = '0;
            end
        end
        else if (tail_reg < head_reg)
        begin
            priority if (BUF_W - head_w >= size_w)
            begin
                fit = 1'b1;
            end
            else if (tail_w >= size_w)
            begin
                fit        = 1'b1;
                fit_rewind = 1'b1;
                fit_base   = '0;
            end
            else
            begin
                fit = 1'b0;
            end
        end
        else
        begin
            fit = (tail_w - head_w >= size_w);
        end
    end

    // pop moves the tail past the front message, clamped to the end of the store
    assign pop_tail = WW'(front) + WW'(cache_len) + HB_W;
    assign pop_next = (pop_tail > BUF_W) ? BUF_W : pop_tail;

    assign a1_addr = (cache_a0_reg == LAST_ADDR) ? '0 : cache_a0_reg + AW'(1);

    // header bytes little endian, then the first message byte
    always_comb
    begin
        priority if (wr_k_reg == HB_K)
        begin
            wr_byte = data_reg;
        end
        else if (wr_k_reg == KW'(0))
        begin
            wr_byte = len_reg[BW-1:0];
        end
        else if (wr_k_reg == KW'(1))
        begin
            wr_byte = {{(2*BW-LW){1'b0}}, len_reg[LW-1:BW]};
        end
        else
        begin
            wr_byte = '0;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        rewind_next       = rewind_reg;
        rewind_valid_next = rewind_valid_reg;
        empty_next        = empty_reg;
        drop_next         = drop_reg;
        push_rem_next     = push_rem_reg;
        rd_off_next       = rd_off_reg;
        data_next         = data_reg;
        len_next          = len_reg;
        status_next       = status_reg;
        rbyte_next        = rbyte_reg;
        rlast_next        = rlast_reg;
        wr_addr_next      = wr_addr_reg;
        wr_k_next         = wr_k_reg;
        rd_addr_next      = rd_addr_reg;
        hdr0_next         = hdr0_reg;
        hdr1_next         = hdr1_reg;
        cache_valid_next  = cache_valid_reg;
        cache_at_next     = cache_at_reg;
        cache_a0_next     = cache_a0_reg;
        cache_a1_next     = cache_a1_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_status_next   = out_status_reg;
        out_rbyte_next    = out_rbyte_reg;
        out_rlast_next    = out_rlast_reg;
        out_hlen_next     = out_hlen_reg;
        out_empty_next    = out_empty_reg;
        mem_we            = 1'b0;
        mem_waddr         = wr_addr_reg;
        mem_wdata         = wr_byte;
        mem_re            = 1'b0;
        mem_raddr         = AW'(rd_addr_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    data_next   = in_data;
                    len_next    = in_len;
                    status_next = lpmf_pkg::ST_OK;
                    rbyte_next  = '0;
                    rlast_next  = 1'b0;
                    state_next  = S_DONE;
                    unique case (lpmf_pkg::req_t'(s_axis_tuser))
                        lpmf_pkg::REQ_PUSH:
                        begin
                            priority if (push_rem_reg != '0)
                            begin
                                push_rem_next = push_rem_reg - LW'(1);
                                if (drop_reg)
                                begin
                                    if (push_rem_reg == LW'(1))
                                    begin
                                        drop_next = 1'b0;
                                    end
                                    status_next = lpmf_pkg::ST_DROP;
                                end
                                else
                                begin
                                    // continuation byte goes inside the reservation, counted back from its end
                                    wr_addr_next = AW'(head_w - WW'(push_rem_reg));
                                    wr_k_next    = HB_K;
                                    state_next   = S_WRITE;
                                end
                            end
                            else if (in_len == '0)
                            begin
                                status_next = lpmf_pkg::ST_DROP;
                            end
                            else if (too_long || !fit)
                            begin
                                push_rem_next = in_len - LW'(1);
                                drop_next     = (in_len != LW'(1));
                                status_next   = lpmf_pkg::ST_DROP;
                            end
                            else
                            begin
                                // reserve header plus message, visible at once
                                if (fit_reset)
                                begin
                                    tail_next         = '0;
                                    rewind_valid_next = 1'b0;
                                end
                                if (fit_rewind)
                                begin
                                    rewind_next       = head_reg;
                                    rewind_valid_next = 1'b1;
                                end
                                head_next     = PW'(fit_base + size_w);
                                wr_addr_next  = AW'(fit_base);
                                wr_k_next     = '0;
                                push_rem_next = in_len - LW'(1);
                                drop_next     = 1'b0;
                                empty_next    = 1'b0;
                                state_next    = S_WRITE;
                            end
                        end
                        lpmf_pkg::REQ_READ:
                        begin
                            if (empty_reg)
                            begin
                                status_next = lpmf_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr_next = WW'(front) + HB_W + WW'(rd_off_reg);
                                if ({1'b0, rd_off_reg} + (LW+1)'(1) >= {1'b0, cache_len})
                                begin
                                    rlast_next  = 1'b1;
                                    rd_off_next = '0;
                                end
                                else
                                begin
                                    rd_off_next = rd_off_reg + LW'(1);
                                end
                                state_next = S_RD_ISSUE;
                            end
                        end
                        lpmf_pkg::REQ_POP:
                        begin
                            if (empty_reg)
                            begin
                                status_next = lpmf_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                if (rewind_valid_reg && (tail_reg == rewind_reg))
                                begin
                                    rewind_valid_next = 1'b0;
                                end
                                tail_next = PW'(pop_next);
                                if (pop_next == head_w)
                                begin
                                    empty_next = 1'b1;
                                end
                                rd_off_next = '0;
                                state_next  = S_REFRESH;
                            end
                        end
                        lpmf_pkg::REQ_CLEAR:
                        begin
                            head_next         = '0;
                            tail_next         = '0;
                            rewind_valid_next = 1'b0;
                            empty_next        = 1'b1;
                            push_rem_next     = '0;
                            drop_next         = 1'b0;
                            rd_off_next       = '0;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                if (wr_k_reg == HB_K)
                begin
                    state_next = need_hdr ? S_REFRESH : S_DONE;
                end
                else
                begin
                    wr_addr_next = wr_addr_reg + AW'(1);
                    wr_k_next    = wr_k_reg + KW'(1);
                end
            end
            S_RD_ISSUE:
            begin
                // fold the byte address back into the store, one lap a cycle
                if (rd_addr_reg >= BUF_W)
                begin
                    rd_addr_next = rd_addr_reg - BUF_W;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_RD_WAIT;
                end
            end
            S_RD_WAIT:
            begin
                rbyte_next = mem_q_reg;
                state_next = S_DONE;
            end
            S_REFRESH:
            begin
                if (need_hdr)
                begin
                    cache_valid_next = 1'b0;
                    cache_at_next    = front;
                    rd_addr_next     = WW'(front);
                    state_next       = S_HDR_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_HDR_A:
            begin
                if (rd_addr_reg >= BUF_W)
                begin
                    rd_addr_next = rd_addr_reg - BUF_W;
                end
                else
                begin
                    mem_re        = 1'b1;
                    cache_a0_next = AW'(rd_addr_reg);
                    state_next    = S_HDR_B;
                end
            end
            S_HDR_B:
            begin
                hdr0_next     = mem_q_reg;
                cache_a1_next = a1_addr;
                if (HEADER_BYTES > 1)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = a1_addr;
                    state_next = S_HDR_C;
                end
                else
                begin
                    cache_valid_next = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_HDR_C:
            begin
                hdr1_next        = mem_q_reg[1:0];
                cache_valid_next = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_rbyte_next  = rbyte_reg;
                    out_rlast_next  = rlast_reg;
                    out_hlen_next   = empty_reg ? '0 : cache_len;
                    out_empty_next  = empty_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // keep the header copy equal to memory when a write lands on it
        if (mem_we && cache_valid_reg)
        begin
            if (mem_waddr == cache_a0_reg)
            begin
                hdr0_next = mem_wdata;
            end
            if ((HEADER_BYTES > 1) && (mem_waddr == cache_a1_reg))
            begin
                hdr1_next = mem_wdata[1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= byte_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            tail_reg         <= '0;
            rewind_reg       <= '0;
            rewind_valid_reg <= 1'b0;
            empty_reg        <= 1'b1;
            drop_reg         <= 1'b0;
            push_rem_reg     <= '0;
            rd_off_reg       <= '0;
            cache_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            rewind_reg       <= rewind_next;
            rewind_valid_reg <= rewind_valid_next;
            empty_reg        <= empty_next;
            drop_reg         <= drop_next;
            push_rem_reg     <= push_rem_next;
            rd_off_reg       <= rd_off_next;
            cache_valid_reg  <= cache_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        data_reg       <= data_next;
        len_reg        <= len_next;
        status_reg     <= status_next;
        rbyte_reg      <= rbyte_next;
        rlast_reg      <= rlast_next;
        wr_addr_reg    <= wr_addr_next;
        wr_k_reg       <= wr_k_next;
        rd_addr_reg    <= rd_addr_next;
        hdr0_reg       <= hdr0_next;
        hdr1_reg       <= hdr1_next;
        cache_at_reg   <= cache_at_next;
        cache_a0_reg   <= cache_a0_next;
        cache_a1_reg   <= cache_a1_next;
        out_status_reg <= out_status_next;
        out_rbyte_reg  <= out_rbyte_next;
        out_rlast_reg  <= out_rlast_next;
        out_hlen_reg   <= out_hlen_next;
        out_empty_reg  <= out_empty_next;
    end

`ifndef ASSERT_OFF
    // an empty queue reports no head length
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[BW+LW] |-> m_axis_tdata[BW+LW-1:BW] == '0)
        else $error("head length nonzero on empty queue");

    // a last mark only comes with a successful read
    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == lpmf_pkg::ST_OK)
        else $error("last mark without ok status");

    // one request in work at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // pointers stay inside the store
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= BUF_P && tail_reg <= BUF_P)
        else $error("pointer beyond store");

    // a non-empty queue always has its front length on hand between requests
    a_cache_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && !empty_reg |-> cache_valid_reg)
        else $error("front length copy missing");
`endif

endmodule
